// File: rtl/core/lthdr_pkg.sv
package lthdr_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int PTR_W   = 8;
  localparam int WORD_W  = 16;
  localparam int SIDES_W = 8;
  localparam int CNT_W   = 9;

  // LFSR shifts per roll and the bit that takes the feedback
  localparam int ROLL_SHIFTS = 16;
  localparam int TOP_BIT     = 15;
  localparam int SHIFT_CNT_W = $clog2(ROLL_SHIFTS);
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  // Tap count after reset
  localparam logic [CNT_W-1:0] HOP_SPAN_RST = CNT_W'(256);

  // Request command codes
  localparam logic [CMD_W-1:0] CMD_WR_TAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEED   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ROLL   = 2'd2;

  typedef enum logic [1:0] {
    DivSrcSlot = 2'd0,
    DivSrcWrap = 2'd1,
    DivSrcRaw  = 2'd2
  } div_src_e;

  typedef struct packed {
    logic     latch_in;
    logic     tap_wr;
    logic     seed_ld;
    logic     div_start;
    div_src_e div_src;
    logic     ptr_ld_rem;
    logic     wrap_ld;
    logic     shift;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic ptr_ge_cnt;
    logic div_busy;
  } dp_sts_t;

endpackage

// File: rtl/core/lfsr_tap_hopping_die_roller.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i (no wait)         cfg_wdata_i = tap entries in use
// in        in         in_valid_i / in_ready_o    command, tap_slot, word_value,
//                                                 entropy_bit, die_sides
// out       out        out_valid_o / out_ready_i  die_value, raw_bits
//
// Steps: a tap write or an unused command is done when taken; a seed reduces the
//   slot mod count in a 16-step shared divider; a roll makes 16 LFSR shifts, one
//   per cycle, then 16 divider steps for word mod sides. A roll starting with the
//   pointer at or past the tap count first works out the wrap remainder.
// Reset: async, active low; LFSR state 1, pointer 0, tap count 256. The tap
//   table is not cleared.
// Stalls: a new request is taken while a result waits; a finished roll holds
//   in the controller until the output register is free.
module lfsr_tap_hopping_die_roller #(
  parameter int unsigned TAP_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lthdr_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lthdr_pkg::CMD_W-1:0]      command_i,
  input  logic [lthdr_pkg::PTR_W-1:0]      tap_slot_i,
  input  logic [lthdr_pkg::WORD_W-1:0]     word_value_i,
  input  logic                             entropy_bit_i,
  input  logic [lthdr_pkg::SIDES_W-1:0]    die_sides_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lthdr_pkg::SIDES_W-1:0]    die_value_o,
  output logic [lthdr_pkg::WORD_W-1:0]     raw_bits_o
);
  import lthdr_pkg::*;

  // controller drives, datapath reports pointer range and divider busy
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  lthdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // LFSR, tap table, pointer hopping and the shared remainder unit
  lthdr_dp #(
    .TAP_DEPTH (TAP_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .tap_slot_i    (tap_slot_i),
    .word_value_i  (word_value_i),
    .entropy_bit_i (entropy_bit_i),
    .die_sides_i   (die_sides_i),
    .die_value_o   (die_value_o),
    .raw_bits_o    (raw_bits_o)
  );

endmodule

// File: rtl/core/lthdr_div.sv
module lthdr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lthdr_pkg::WORD_W-1:0]    dividend_i,
  input  logic [lthdr_pkg::CNT_W-1:0]     divisor_i,
  output logic                            busy_o,
  output logic [lthdr_pkg::CNT_W-1:0]     rem_o
);
  import lthdr_pkg::*;

  // restoring division, one dividend bit per cycle
  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]    dvd_q, dvd_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W:0]       trial;

  assign trial = {rem_q, dvd_q[WORD_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##17 !busy_q)
    else $error("divider did not finish after a full dividend");
`endif

endmodule

// File: rtl/core/lthdr_dp.sv
module lthdr_dp #(
  parameter int unsigned TAP_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lthdr_pkg::dp_cmd_t               cmd_i,
  output lthdr_pkg::dp_sts_t               sts_o,
  input  logic                             cfg_we_i,
  input  logic [lthdr_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic [lthdr_pkg::PTR_W-1:0]      tap_slot_i,
  input  logic [lthdr_pkg::WORD_W-1:0]     word_value_i,
  input  logic                             entropy_bit_i,
  input  logic [lthdr_pkg::SIDES_W-1:0]    die_sides_i,
  output logic [lthdr_pkg::SIDES_W-1:0]    die_value_o,
  output logic [lthdr_pkg::WORD_W-1:0]     raw_bits_o
);
  import lthdr_pkg::*;

  localparam int AW      = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int PW      = (AW > PTR_W) ? AW : PTR_W;
  localparam int CNT_MAX = (TAP_DEPTH < 256) ? TAP_DEPTH : 256;
  localparam logic [CNT_W-1:0] CntMaxW = CNT_W'(CNT_MAX);

  // config
  logic [CNT_W-1:0] hop_span_q;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_span_q <= HOP_SPAN_RST;
    end else if (cfg_we_i) begin
      hop_span_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, clamp to the table size and to at most 256
  always_comb begin
    if (hop_span_q == '0) begin
      cnt = CNT_W'(1);
    end else if (hop_span_q > CntMaxW) begin
      cnt = CntMaxW;
    end else begin
      cnt = hop_span_q;
    end
  end

  // state
  logic [WORD_W-1:0] lfsr_q, lfsr_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [PTR_W-1:0]  wrap_q;
  logic [WORD_W-1:0] collect_q;
  logic              ent_q;
  logic [SIDES_W-1:0] sides_q;
  logic [SIDES_W-1:0] die_q;
  logic [WORD_W-1:0] raw_q;

  // tap memory, read every cycle at the next pointer
  logic [WORD_W-1:0] tap_mem [TAP_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              rng_q;
  logic [PW-1:0]     rd_ext, wr_ext;
  logic              rd_ok, wr_ok;

  assign rd_ext = PW'(ptr_d);
  assign wr_ext = PW'(tap_slot_i);
  assign rd_ok  = 32'(ptr_d) < 32'(TAP_DEPTH);
  assign wr_ok  = cmd_i.tap_wr && (32'(tap_slot_i) < 32'(TAP_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      tap_mem[wr_ext[AW-1:0]] <= word_value_i;
    end
    rdata_q <= tap_mem[rd_ext[AW-1:0]];
    rng_q   <= rd_ok;
  end

  // divider
  logic [WORD_W-1:0] div_dvd;
  logic [CNT_W-1:0]  div_dvs;
  logic [CNT_W-1:0]  div_rem;
  logic              div_busy;
  logic [CNT_W-1:0]  ptr_inc;

  assign ptr_inc = {1'b0, ptr_q} + CNT_W'(1);

  always_comb begin
    unique case (cmd_i.div_src)
      DivSrcSlot: begin
        div_dvd = WORD_W'(tap_slot_i);
        div_dvs = cnt;
      end
      DivSrcWrap: begin
        div_dvd = WORD_W'(ptr_inc);
        div_dvs = cnt;
      end
      DivSrcRaw: begin
        div_dvd = collect_q;
        div_dvs = CNT_W'(sides_q);
      end
      default: begin
        div_dvd = collect_q;
        div_dvs = CNT_W'(sides_q);
      end
    endcase
  end

  lthdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // one LFSR shift
  logic [WORD_W-1:0] mask;
  logic              fb, nb, adv, ptr_ge;
  logic [WORD_W-1:0] s_new;
  logic [PTR_W-1:0]  ptr_adv;

  assign ptr_ge = {1'b0, ptr_q} >= cnt;
  assign mask   = rng_q ? rdata_q : '0;
  assign fb     = ^(lfsr_q & mask);
  assign nb     = fb ^ ent_q;
  assign s_new  = {nb, lfsr_q[TOP_BIT:1]};
  assign adv    = (fb == ent_q) && (s_new[0] == ent_q) && ((^s_new) == s_new[1]);

  always_comb begin
    if (ptr_ge) begin
      ptr_adv = wrap_q;
    end else if (ptr_inc == cnt) begin
      ptr_adv = '0;
    end else begin
      ptr_adv = ptr_inc[PTR_W-1:0];
    end
  end

  always_comb begin
    priority if (cmd_i.ptr_ld_rem) begin
      ptr_d = div_rem[PTR_W-1:0];
    end else if (cmd_i.shift && adv) begin
      ptr_d = ptr_adv;
    end else begin
      ptr_d = ptr_q;
    end
  end

  always_comb begin
    priority if (cmd_i.seed_ld) begin
      lfsr_d = word_value_i;
    end else if (cmd_i.shift) begin
      lfsr_d = s_new;
    end else begin
      lfsr_d = lfsr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= WORD_W'(1);
      ptr_q  <= '0;
    end else begin
      lfsr_q <= lfsr_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      ent_q     <= entropy_bit_i;
      sides_q   <= die_sides_i;
      collect_q <= '0;
    end else if (cmd_i.shift) begin
      collect_q <= {collect_q[WORD_W-2:0], s_new[0]};
    end
    if (cmd_i.wrap_ld) begin
      wrap_q <= div_rem[PTR_W-1:0];
    end
    if (cmd_i.out_ld) begin
      // zero sides reports face zero
      die_q <= (sides_q == '0) ? '0 : SIDES_W'(div_rem + CNT_W'(1));
      raw_q <= collect_q;
    end
  end

  assign sts_o.ptr_ge_cnt = ptr_ge;
  assign sts_o.div_busy   = div_busy;
  assign die_value_o      = die_q;
  assign raw_bits_o       = raw_q;

`ifndef NO_ASSERTIONS
  a_adv_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && adv) |=> ({1'b0, ptr_q} < cnt))
    else $error("tap pointer advanced past the tap count");

  a_seed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ptr_ld_rem |=> ({1'b0, ptr_q} < cnt))
    else $error("seeded tap pointer not below the tap count");
`endif

endmodule

// File: rtl/core/lthdr_ctrl.sv
module lthdr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lthdr_pkg::CMD_W-1:0]   command_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lthdr_pkg::dp_cmd_t            cmd_o,
  input  lthdr_pkg::dp_sts_t            sts_i
);
  import lthdr_pkg::*;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StSeedDiv = 7'b0000010,
    StWrapDiv = 7'b0000100,
    StShift   = 7'b0001000,
    StModGo   = 7'b0010000,
    StModDiv  = 7'b0100000,
    StFinish  = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [SHIFT_CNT_W-1:0] shift_cnt_q, shift_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;
  dp_cmd_t                cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    shift_cnt_d = shift_cnt_q;
    cmd         = '0;
    cmd.div_src = DivSrcRaw;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (command_i)
            CMD_WR_TAP: begin
              cmd.tap_wr = 1'b1;
            end
            CMD_SEED: begin
              cmd.seed_ld   = 1'b1;
              cmd.div_start = 1'b1;
              cmd.div_src   = DivSrcSlot;
              state_d       = StSeedDiv;
            end
            CMD_ROLL: begin
              cmd.latch_in = 1'b1;
              shift_cnt_d  = '0;
              if (sts_i.ptr_ge_cnt) begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DivSrcWrap;
                state_d       = StWrapDiv;
              end else begin
                state_d = StShift;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StSeedDiv: begin
        if (!sts_i.div_busy) begin
          cmd.ptr_ld_rem = 1'b1;
          state_d        = StIdle;
        end
      end
      StWrapDiv: begin
        if (!sts_i.div_busy) begin
          cmd.wrap_ld = 1'b1;
          state_d     = StShift;
        end
      end
      StShift: begin
        cmd.shift   = 1'b1;
        shift_cnt_d = shift_cnt_q + SHIFT_CNT_W'(1);
        if (shift_cnt_q == SHIFT_CNT_W'(ROLL_SHIFTS - 1)) begin
          state_d = StModGo;
        end
      end
      StModGo: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DivSrcRaw;
        state_d       = StModDiv;
      end
      StModDiv: begin
        if (!sts_i.div_busy) begin
          if (out_free) begin
            cmd.out_ld = 1'b1;
            state_d    = StIdle;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      shift_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shift_cnt_q <= shift_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !sts_i.div_busy)
    else $error("idle with the divider still running");

  a_shift_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StModGo) |-> $past(state_q == StShift))
    else $error("reduction started without a finished shift run");
`endif

endmodule

// File: test/lfsr_tap_hopping_die_roller_tb.sv
`timescale 1ns / 100ps

module lfsr_tap_hopping_die_roller_tb;
  import lthdr_pkg::*;

  // Table depth used for the build under test
  localparam int unsigned TAP_ENTRIES = 256;
  // Opcode with no named constant in the package; the block drops it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Worst case for a request with no result: a seed runs the 16-step divider
  localparam int SETTLE_CYCLES = 40;
  // Cycle limit for the whole run, taken several times over what the requests need
  localparam int CYCLE_LIMIT = 500_000;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic [SIDES_W-1:0] face;
    logic [WORD_W-1:0]  raw;
  } roll_result_t;

  // Tracks the roller's state, predicts every roll and checks what comes out.
  class die_roll_scoreboard;
    logic [WORD_W-1:0]  lfsr_q;
    logic [PTR_W-1:0]   hop_ptr;
    logic [CNT_W-1:0]   hop_span;
    logic [WORD_W-1:0]  tap_mask[TAP_ENTRIES];
    bit                 mask_loaded[TAP_ENTRIES];
    roll_result_t       pending_rolls[$];
    int                 mismatches;

    function new();
      lfsr_q     = 16'd1;
      hop_ptr    = '0;
      hop_span   = HOP_SPAN_RST;
      mismatches = 0;
      foreach (mask_loaded[i]) begin
        mask_loaded[i] = 1'b0;
        tap_mask[i]    = '0;
      end
    endfunction

    // Count 0 behaves as 1; anything past the table is clamped
    function int unsigned hop_limit();
      int unsigned c;
      c = hop_span;
      if (c == 0) c = 1;
      if (c > 256) c = 256;
      if (c > TAP_ENTRIES) c = TAP_ENTRIES;
      return c;
    endfunction

    function void set_hop_span(logic [CNT_W-1:0] v);
      hop_span = v;
    endfunction

    // Sixteen shifts; miss returns the first table slot read before it was loaded
    function void predict_roll(input logic ent, inout logic [WORD_W-1:0] st,
                               inout logic [PTR_W-1:0] ptr,
                               output logic [WORD_W-1:0] raw, output int miss);
      int unsigned lim;
      logic fb;
      logic nb;
      lim  = hop_limit();
      raw  = '0;
      miss = -1;
      for (int i = 0; i < ROLL_SHIFTS; i++) begin
        if (ptr >= TAP_ENTRIES) begin
          fb = 1'b0;
        end else begin
          if (!mask_loaded[ptr] && miss < 0) miss = int'(ptr);
          fb = ^(st & tap_mask[ptr]);
        end
        nb  = fb ^ ent;
        st  = {nb, st[TOP_BIT:1]};
        raw = {raw[WORD_W-2:0], st[0]};
        // hop only when feedback, new low bit and state parity all line up
        if (fb == ent && st[0] == ent && (^st) == st[1])
          ptr = PTR_W'((int'(ptr) + 1) % lim);
      end
    endfunction

    // Dry run of a roll from the current state
    function int unloaded_slot(logic ent);
      logic [WORD_W-1:0] st;
      logic [PTR_W-1:0]  ptr;
      logic [WORD_W-1:0] raw;
      int miss;
      st  = lfsr_q;
      ptr = hop_ptr;
      predict_roll(ent, st, ptr, raw, miss);
      return miss;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [PTR_W-1:0] slot,
                               logic [WORD_W-1:0] word, logic ent,
                               logic [SIDES_W-1:0] sides);
      roll_result_t want;
      int miss;
      case (cmd)
        CMD_WR_TAP: begin
          if (slot < TAP_ENTRIES) begin
            tap_mask[slot]    = word;
            mask_loaded[slot] = 1'b1;
          end
        end
        CMD_SEED: begin
          lfsr_q  = word;
          hop_ptr = PTR_W'(int'(slot) % hop_limit());
        end
        CMD_ROLL: begin
          predict_roll(ent, lfsr_q, hop_ptr, want.raw, miss);
          // zero sides is flagged with a zero face
          want.face = (sides == 0) ? '0 :
                      SIDES_W'((int'(want.raw) % int'(sides)) + 1);
          pending_rolls.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_roll(logic [SIDES_W-1:0] face, logic [WORD_W-1:0] raw);
      roll_result_t want;
      if (pending_rolls.size() == 0) begin
        note_failure($sformatf("[%0t] unexpected roll: face %0d raw %04h",
                               $realtime, face, raw));
        return;
      end
      want = pending_rolls.pop_front();
      if (face !== want.face || raw !== want.raw)
        note_failure($sformatf("[%0t] roll mismatch: face exp %0d got %0d, raw exp %04h got %04h",
                               $realtime, want.face, face, want.raw, raw));
    endfunction

    function int pending();
      return pending_rolls.size();
    endfunction
  endclass

  // Every input starts at a known value
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i     = '0;
  logic [PTR_W-1:0]   tap_slot_i    = '0;
  logic [WORD_W-1:0]  word_value_i  = '0;
  logic               entropy_bit_i = 1'b0;
  logic [SIDES_W-1:0] die_sides_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [SIDES_W-1:0] die_value_o;
  logic [WORD_W-1:0]  raw_bits_o;

  die_roll_scoreboard ledger = new();

  int in_idle_pct  = 34;
  int out_idle_pct = 34;
  int cycle_count  = 0;

  lfsr_tap_hopping_die_roller #(
    .TAP_DEPTH(TAP_ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .tap_slot_i   (tap_slot_i),
    .word_value_i (word_value_i),
    .entropy_bit_i(entropy_bit_i),
    .die_sides_i  (die_sides_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .die_value_o  (die_value_o),
    .raw_bits_o   (raw_bits_o)
  );

  always #2 clk_i = ~clk_i;

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  // Result monitor: values sampled here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_roll(die_value_o, raw_bits_o);
  end

  // One request. Valid is dropped only when a gap is taken, so a request that
  // follows straight on keeps valid high with no glitch in the same step.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PTR_W-1:0] slot,
                              input logic [WORD_W-1:0] word, input logic ent,
                              input logic [SIDES_W-1:0] sides);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    tap_slot_i    <= slot;
    word_value_i  <= word;
    entropy_bit_i <= ent;
    die_sides_i   <= sides;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_request(cmd, slot, word, ent, sides);
  endtask

  // A roll must never read a table slot that was never written, so any
  // slot the dry run would touch first gets a random mask loaded.
  task automatic roll_die(input logic ent, input logic [SIDES_W-1:0] sides);
    int gap_slot;
    gap_slot = ledger.unloaded_slot(ent);
    while (gap_slot >= 0) begin
      send_request(CMD_WR_TAP, PTR_W'(gap_slot), WORD_W'($urandom), 1'($urandom),
                   SIDES_W'($urandom));
      gap_slot = ledger.unloaded_slot(ent);
    end
    send_request(CMD_ROLL, PTR_W'($urandom), WORD_W'($urandom), ent, sides);
  endtask

  // Sender stops until all rolls are back, then waits out any seed still
  // in the divider before the block counts as idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_hop_count(input logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.set_hop_span(value);
  endtask

  task automatic random_phase(input int n_items);
    int pick;
    int kind;
    logic [SIDES_W-1:0] sides;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // bias die sizes toward the edges: zero, one, 255, powers of two
        kind = $urandom_range(19);
        if (kind == 0) sides = '0;
        else if (kind == 1) sides = 8'd255;
        else if (kind == 2) sides = 8'd1;
        else if (kind < 6) sides = SIDES_W'(1 << $urandom_range(7));
        else sides = SIDES_W'($urandom_range(255, 1));
        roll_die(1'($urandom), sides);
      end else if (pick < 80) begin
        send_request(CMD_WR_TAP, PTR_W'($urandom), WORD_W'($urandom), 1'($urandom),
                     SIDES_W'($urandom));
      end else if (pick < 94) begin
        send_request(CMD_SEED, PTR_W'($urandom), WORD_W'($urandom), 1'($urandom),
                     SIDES_W'($urandom));
      end else begin
        send_request(CMD_UNUSED, PTR_W'($urandom), WORD_W'($urandom), 1'($urandom),
                     SIDES_W'($urandom));
      end
    end
  endtask

  logic [CNT_W-1:0] hop_settings[8];
  int errors;

  initial begin
    hop_settings = '{9'd0, 9'd1, 9'd511, 9'd257, 9'd2, 9'd255, 9'd256, 9'd0};
    hop_settings[7] = CNT_W'($urandom_range(64, 3));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, tap count still at its reset value.
    // Mask extremes: standard taps, all ones, all zeros.
    send_request(CMD_WR_TAP, 8'd0,   16'hB400, 1'b0, 8'd0);
    send_request(CMD_WR_TAP, 8'd255, 16'hFFFF, 1'b1, 8'hFF);
    send_request(CMD_WR_TAP, 8'd1,   16'h0000, 1'b0, 8'd0);
    // first rolls run from the reset state
    roll_die(1'b0, 8'd6);
    roll_die(1'b1, 8'd255);
    roll_die(1'b0, 8'd1);
    roll_die(1'b1, 8'd0);        // zero sides: face comes back as 0
    // top slot: the next hop wraps to slot 0
    send_request(CMD_SEED, 8'd255, 16'hFFFF, 1'b1, 8'hFF);
    roll_die(1'b1, 8'd128);
    roll_die(1'b0, 8'd2);
    // all-zero seed
    send_request(CMD_SEED, 8'd0, 16'h0000, 1'b0, 8'd0);
    roll_die(1'b0, 8'd17);
    roll_die(1'b1, 8'd255);
    // unused opcode with every field bit set: nothing should come back
    send_request(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 8'hFF);
    // park the pointer high, then shrink the count under it
    send_request(CMD_SEED, 8'd200, 16'hACE1, 1'b0, 8'd0);
    drain();
    set_hop_count(9'd4);
    roll_die(1'b1, 8'd100);
    roll_die(1'b0, 8'd3);

    // Random part: one phase per count setting, block idle at each change
    foreach (hop_settings[i]) begin
      drain();
      set_hop_count(hop_settings[i]);
      // one stretch with no stalls on either side
      in_idle_pct  = (i == 2) ? 0 : 34;
      out_idle_pct = (i == 2) ? 0 : 34;
      random_phase(ITEMS_PER_PHASE);
    end

    drain();
    errors = ledger.mismatches + ledger.pending();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
